@@ design/rlebpe_pkg.sv @@
// ----------------------------------------------------------------------------
// rlebpe_pkg
// shared types and constants of the run-length byte pair encoder
// ----------------------------------------------------------------------------
package rlebpe_pkg;

  localparam int DATA_W        = 8;
  localparam int LIMIT_W       = 24;
  localparam int BYTES_W       = 25;
  localparam int RUN_MAX       = 255;
  localparam int PAIR_BYTES    = 2;
  localparam int LIMIT_RESET   = 1;
  localparam int QUEUE_DEPTH_D = 2;

  // one (count, value) pair as it leaves the block
  typedef struct packed {
    logic [DATA_W-1:0]  run_length;
    logic [DATA_W-1:0]  run_value;
    logic               end_of_block;
    logic               too_cluttered;
    logic [BYTES_W-1:0] out_bytes;
  } pair_t;

  // one request from the front: first pair always valid, second optional
  typedef struct packed {
    logic  second_valid;
    pair_t first;
    pair_t second;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ design/rlebpe_in_if.sv @@
// ----------------------------------------------------------------------------
// rlebpe_in_if
// source byte channel: valid, ready, byte and end-of-block flag
// ----------------------------------------------------------------------------
interface rlebpe_in_if;
  logic                       valid;
  logic                       ready;
  logic [rlebpe_pkg::DATA_W-1:0] data_byte;
  logic                       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ design/rlebpe_out_if.sv @@
// ----------------------------------------------------------------------------
// rlebpe_out_if
// encoded pair channel: valid, ready and one (count, value) pair
// ----------------------------------------------------------------------------
interface rlebpe_out_if;
  logic                           valid;
  logic                           ready;
  logic [rlebpe_pkg::DATA_W-1:0]  run_length;
  logic [rlebpe_pkg::DATA_W-1:0]  run_value;
  logic                           end_of_block;
  logic                           too_cluttered;
  logic [rlebpe_pkg::BYTES_W-1:0] out_bytes;

  modport source (output valid, output run_length, output run_value,
                  output end_of_block, output too_cluttered, output out_bytes,
                  input ready);
  modport sink   (input valid, input run_length, input run_value,
                  input end_of_block, input too_cluttered, input out_bytes,
                  output ready);
endinterface

@@ design/rlebpe_front.sv @@
// ----------------------------------------------------------------------------
// rlebpe_front
// run tracking: accepts source bytes and turns them into pair requests
// ----------------------------------------------------------------------------
module rlebpe_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [rlebpe_pkg::LIMIT_W-1:0] source_length,
  rlebpe_in_if.sink                     in_ch,
  input  rlebpe_pkg::q_stat_t           q_stat,
  output logic                          push,
  output rlebpe_pkg::req_t              push_req
);
  import rlebpe_pkg::*;

  localparam logic [DATA_W-1:0]  RUN_MAX_V = DATA_W'(RUN_MAX);
  localparam logic [BYTES_W-1:0] INC1      = BYTES_W'(PAIR_BYTES);
  localparam logic [BYTES_W-1:0] INC2      = BYTES_W'(2 * PAIR_BYTES);

  logic [DATA_W-1:0]  cur_value_r, cur_value_nxt;
  logic [DATA_W-1:0]  run_count_r, run_count_nxt;
  logic [BYTES_W-1:0] bytes_r, bytes_nxt;
  logic               started_r, started_nxt;
  logic               aborted_r, aborted_nxt;

  logic               accept;
  logic [BYTES_W-1:0] bytes_one, bytes_two, limit;
  logic               clut_one, clut_two;
  logic [DATA_W-1:0]  b;
  logic               last;

  function automatic pair_t make_pair(input logic [DATA_W-1:0] len,
                                      input logic [DATA_W-1:0] val,
                                      input logic eob,
                                      input logic clut,
                                      input logic [BYTES_W-1:0] cnt);
    pair_t p;
    p.run_length    = len;
    p.run_value     = val;
    p.end_of_block  = eob | clut;
    p.too_cluttered = clut;
    p.out_bytes     = cnt;
    return p;
  endfunction

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign last        = in_ch.last_byte;

  assign limit     = BYTES_W'(source_length);
  assign bytes_one = bytes_r + INC1;
  assign bytes_two = bytes_r + INC2;
  assign clut_one  = bytes_one >= limit;
  assign clut_two  = bytes_two >= limit;

  always_comb begin
    cur_value_nxt = cur_value_r;
    run_count_nxt = run_count_r;
    bytes_nxt     = bytes_r;
    started_nxt   = started_r;
    aborted_nxt   = aborted_r;
    push          = 1'b0;
    push_req      = '0;
    if (accept) begin
      if (aborted_r) begin
        // rest of an aborted block is dropped, last byte closes it
        if (last) begin
          aborted_nxt = 1'b0;
          started_nxt = 1'b0;
          bytes_nxt   = '0;
          run_count_nxt = '0;
          cur_value_nxt = '0;
        end
      end else if (!started_r) begin
        if (last) begin
          push           = 1'b1;
          push_req.first = make_pair(DATA_W'(1), b, 1'b1, clut_one, bytes_one);
          started_nxt    = 1'b0;
          bytes_nxt      = '0;
          run_count_nxt  = '0;
          cur_value_nxt  = '0;
        end else begin
          started_nxt   = 1'b1;
          bytes_nxt     = '0;
          cur_value_nxt = b;
          run_count_nxt = DATA_W'(1);
        end
      end else if ((b != cur_value_r) || (run_count_r == RUN_MAX_V)) begin
        // value change or full run: the open run goes out
        push           = 1'b1;
        push_req.first = make_pair(run_count_r, cur_value_r, 1'b0, clut_one, bytes_one);
        if (clut_one || last) begin
          if (!clut_one) begin
            push_req.second_valid = 1'b1;
            push_req.second = make_pair(DATA_W'(1), b, 1'b1, clut_two, bytes_two);
          end
          aborted_nxt   = clut_one && !last;
          started_nxt   = clut_one && !last;
          bytes_nxt     = (clut_one && !last) ? bytes_one : '0;
          run_count_nxt = '0;
          cur_value_nxt = '0;
        end else begin
          bytes_nxt     = bytes_one;
          cur_value_nxt = b;
          run_count_nxt = DATA_W'(1);
        end
      end else begin
        if (last) begin
          push           = 1'b1;
          push_req.first = make_pair(run_count_r + DATA_W'(1), cur_value_r, 1'b1,
                                     clut_one, bytes_one);
          started_nxt    = 1'b0;
          bytes_nxt      = '0;
          run_count_nxt  = '0;
          cur_value_nxt  = '0;
        end else begin
          run_count_nxt = run_count_r + DATA_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_value_r <= '0;
      run_count_r <= '0;
      bytes_r     <= '0;
      started_r   <= 1'b0;
      aborted_r   <= 1'b0;
    end else begin
      cur_value_r <= cur_value_nxt;
      run_count_r <= run_count_nxt;
      bytes_r     <= bytes_nxt;
      started_r   <= started_nxt;
      aborted_r   <= aborted_nxt;
    end
  end

endmodule

@@ design/rlebpe_queue.sv @@
// ----------------------------------------------------------------------------
// rlebpe_queue
// small request queue between front and back
// ----------------------------------------------------------------------------
module rlebpe_queue #(
  parameter int DEPTH = rlebpe_pkg::QUEUE_DEPTH_D
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rlebpe_pkg::req_t    push_req,
  input  logic                pop,
  output rlebpe_pkg::req_t    head,
  output rlebpe_pkg::q_stat_t stat
);
  import rlebpe_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  req_t             entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (count_r == FULL_CNT);
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    if (do_push && !do_pop)      count_nxt = count_r + CNT_W'(1);
    else if (!do_push && do_pop) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_req;
  end

endmodule

@@ design/rlebpe_back.sv @@
// ----------------------------------------------------------------------------
// rlebpe_back
// pair output: sends the one or two pairs of each request in order
// ----------------------------------------------------------------------------
module rlebpe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  rlebpe_pkg::req_t    head,
  input  rlebpe_pkg::q_stat_t q_stat,
  output logic                pop,
  rlebpe_out_if.source        out_ch
);
  import rlebpe_pkg::*;

  logic  sel_r, sel_nxt;
  logic  hs;
  pair_t cur;

  assign cur                  = sel_r ? head.second : head.first;
  assign out_ch.valid         = !q_stat.empty;
  assign out_ch.run_length    = cur.run_length;
  assign out_ch.run_value     = cur.run_value;
  assign out_ch.end_of_block  = cur.end_of_block;
  assign out_ch.too_cluttered = cur.too_cluttered;
  assign out_ch.out_bytes     = cur.out_bytes;

  assign hs      = out_ch.valid && out_ch.ready;
  assign pop     = hs && (sel_r || !head.second_valid);
  assign sel_nxt = hs ? (!sel_r && head.second_valid) : sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

endmodule

@@ design/rle_byte_pair_encoder_top.sv @@
// ----------------------------------------------------------------------------
// rle_byte_pair_encoder_top
// run-length encoder emitting (count, value) byte pairs per source block
// ----------------------------------------------------------------------------
// source bytes enter one per cycle on in_ch while the queue is not full, with
// last_byte on the final byte of a block; pairs leave one per cycle on out_ch
// while the sink is ready. a byte's pairs are queued before out_ch shows them.
// most bytes cause no pair or one pair; a final byte that ends a run yields
// two pairs, sent one after the other, so the sustained rate is one byte per
// cycle until pairs arrive faster than one per cycle, where the single output
// port sets the pace. a request queue of QUEUE_DEPTH entries lets the input
// keep going while a pair waits on a stalled sink. runs longer than 255 are
// split, and once the compressed size reaches source_length the pair that
// reaches it carries too_cluttered and end_of_block, and the rest of that
// block is dropped up to its last byte. the user writes source_length through
// cfg_we / cfg_wdata while the block is idle; the block does not enforce it.
// source_length resets to 1. no clearing pass is run after reset.
module rle_byte_pair_encoder_top #(
  parameter int QUEUE_DEPTH = rlebpe_pkg::QUEUE_DEPTH_D
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rlebpe_pkg::LIMIT_W-1:0] cfg_wdata,
  rlebpe_in_if.sink                      in_ch,
  rlebpe_out_if.source                   out_ch
);
  import rlebpe_pkg::*;

  // limit for the compressed size of a block
  logic [LIMIT_W-1:0] source_length_r;

  // front to back request queue
  logic    push, pop;
  req_t    push_req, head;
  q_stat_t q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_length_r <= LIMIT_W'(LIMIT_RESET);
    end else if (cfg_we) begin
      source_length_r <= cfg_wdata;
    end
  end

  // front: run tracking, size accounting and abort decision
  rlebpe_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .source_length (source_length_r),
    .in_ch         (in_ch),
    .q_stat        (q_stat),
    .push          (push),
    .push_req      (push_req)
  );

  // queue: decouples byte intake from pair output
  rlebpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // back: sends the one or two pairs of each request
  rlebpe_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

@@ design/rlebpe_checker.sv @@
// ----------------------------------------------------------------------------
// rlebpe_checker
// port-level checks on the pair output of the encoder
// ----------------------------------------------------------------------------
module rlebpe_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [rlebpe_pkg::DATA_W-1:0]  run_length,
  input logic [rlebpe_pkg::DATA_W-1:0]  run_value,
  input logic                           end_of_block,
  input logic                           too_cluttered,
  input logic [rlebpe_pkg::BYTES_W-1:0] out_bytes
);
  import rlebpe_pkg::*;

  // a stalled pair holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({run_length, run_value, end_of_block, too_cluttered, out_bytes}))
    else $error("pair changed while stalled");

  // an aborting pair always closes the block
  a_abort_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && too_cluttered |-> end_of_block)
    else $error("too_cluttered without end_of_block");

  // sizes count whole pairs and runs are never empty
  a_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_bytes[0] && (out_bytes != '0) && (run_length != '0))
    else $error("malformed pair");

endmodule

bind rle_byte_pair_encoder_top rlebpe_checker u_rlebpe_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .run_length    (out_ch.run_length),
  .run_value     (out_ch.run_value),
  .end_of_block  (out_ch.end_of_block),
  .too_cluttered (out_ch.too_cluttered),
  .out_bytes     (out_ch.out_bytes)
);
